FILE: sv/websocket_frame_unmasker_unit_macros.svh
// assertion macros for the websocket frame unmasker
// clocked on aclk, disabled or not by aresetn, no other dependencies
`ifndef WEBSOCKET_FRAME_UNMASKER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_UNMASKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// check out of reset
`define WSFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// check at every edge, reset included
`define WSFU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define WSFU_ASSERT(lbl, prop, msg)
`define WSFU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: sv/wsfu_pkg.sv
// shared types and codes of the websocket frame unmasker
// no dependencies
`timescale 1ns / 1ps

package wsfu_pkg;

    // parser phases
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_UNMASKED = 2'd1;
    localparam logic [1:0] KIND_EMPTY    = 2'd2;

    // header decode constants
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [3:0] MASK_BYTES   = 4'd4;

    // one result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] result_kind;
        logic       frame_last;
    } result_t;

endpackage

FILE: sv/wsfu_in_reg.sv
// input register of the websocket frame unmasker
// takes one stream byte per beat; no package dependencies
`timescale 1ns / 1ps

module wsfu_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_stream_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // free when empty or the held byte moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_stream_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

FILE: sv/wsfu_deframer.sv
// frame parser and unmasker: header, length, mask and payload state
// uses wsfu_pkg and the assertion macros header
`timescale 1ns / 1ps
`include "websocket_frame_unmasker_unit_macros.svh"

module wsfu_deframer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic [7:0]       byte_data,
    output logic             res_valid,
    output wsfu_pkg::result_t res
);

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic [63:0] frame_length_reg, frame_length_next;
    logic [31:0] mask_word_reg, mask_word_next;
    logic        mask_flag_reg, mask_flag_next;
    logic [1:0]  mask_position_reg, mask_position_next;
    logic        halted_reg, halted_next;
    logic [7:0]  mask_byte;
    logic [6:0]  len_code;

    assign len_code = byte_data[6:0];

    // mask byte for the current payload position, first received byte first
    always_comb begin
        case (mask_position_reg)
            2'd0:    mask_byte = mask_word_reg[31:24];
            2'd1:    mask_byte = mask_word_reg[23:16];
            2'd2:    mask_byte = mask_word_reg[15:8];
            default: mask_byte = mask_word_reg[7:0];
        endcase
    end

    // next state and result for one byte
    always_comb begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        frame_length_next  = frame_length_reg;
        mask_word_next     = mask_word_reg;
        mask_flag_next     = mask_flag_reg;
        mask_position_next = mask_position_reg;
        halted_next        = halted_reg;
        res_valid          = 1'b0;
        res.out_byte       = 8'd0;
        res.result_kind    = wsfu_pkg::KIND_PAYLOAD;
        res.frame_last     = 1'b0;
        if (!halted_reg) begin
            case (phase_reg)
                wsfu_pkg::PH_HDR0: begin
                    phase_next = wsfu_pkg::PH_HDR1;
                end
                wsfu_pkg::PH_HDR1: begin
                    mask_flag_next = byte_data[7];
                    if (len_code == wsfu_pkg::LEN_CODE_16) begin
                        frame_length_next = 64'd0;
                        header_count_next = wsfu_pkg::EXT_BYTES_16;
                        phase_next        = wsfu_pkg::PH_EXTLEN;
                    end else if (len_code == wsfu_pkg::LEN_CODE_64) begin
                        frame_length_next = 64'd0;
                        header_count_next = wsfu_pkg::EXT_BYTES_64;
                        phase_next        = wsfu_pkg::PH_EXTLEN;
                    end else begin
                        frame_length_next = {57'd0, len_code};
                        if (!byte_data[7]) begin
                            halted_next     = 1'b1;
                            phase_next      = wsfu_pkg::PH_HDR0;
                            res_valid       = 1'b1;
                            res.result_kind = wsfu_pkg::KIND_UNMASKED;
                            res.frame_last  = 1'b1;
                        end else begin
                            header_count_next = wsfu_pkg::MASK_BYTES;
                            phase_next        = wsfu_pkg::PH_MASK;
                        end
                    end
                end
                wsfu_pkg::PH_EXTLEN: begin
                    frame_length_next = {frame_length_reg[55:0], byte_data};
                    header_count_next = header_count_reg - 4'd1;
                    if (header_count_reg == 4'd1) begin
                        if (!mask_flag_reg) begin
                            halted_next     = 1'b1;
                            phase_next      = wsfu_pkg::PH_HDR0;
                            res_valid       = 1'b1;
                            res.result_kind = wsfu_pkg::KIND_UNMASKED;
                            res.frame_last  = 1'b1;
                        end else begin
                            header_count_next = wsfu_pkg::MASK_BYTES;
                            phase_next        = wsfu_pkg::PH_MASK;
                        end
                    end
                end
                wsfu_pkg::PH_MASK: begin
                    mask_word_next    = {mask_word_reg[23:0], byte_data};
                    header_count_next = header_count_reg - 4'd1;
                    if (header_count_reg == 4'd1) begin
                        mask_position_next = 2'd0;
                        if (frame_length_reg == 64'd0) begin
                            phase_next      = wsfu_pkg::PH_HDR0;
                            res_valid       = 1'b1;
                            res.result_kind = wsfu_pkg::KIND_EMPTY;
                            res.frame_last  = 1'b1;
                        end else begin
                            phase_next = wsfu_pkg::PH_PAYLOAD;
                        end
                    end
                end
                wsfu_pkg::PH_PAYLOAD: begin
                    mask_position_next = mask_position_reg + 2'd1;
                    frame_length_next  = frame_length_reg - 64'd1;
                    res_valid          = 1'b1;
                    res.out_byte       = byte_data ^ mask_byte;
                    if (frame_length_reg == 64'd1) begin
                        res.frame_last = 1'b1;
                        phase_next     = wsfu_pkg::PH_HDR0;
                    end
                end
                default: begin
                    phase_next = wsfu_pkg::PH_HDR0;
                end
            endcase
        end
    end

    // state update on each consumed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= wsfu_pkg::PH_HDR0;
            header_count_reg  <= 4'd0;
            frame_length_reg  <= 64'd0;
            mask_word_reg     <= 32'd0;
            mask_flag_reg     <= 1'b0;
            mask_position_reg <= 2'd0;
            halted_reg        <= 1'b0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            frame_length_reg  <= frame_length_next;
            mask_word_reg     <= mask_word_next;
            mask_flag_reg     <= mask_flag_next;
            mask_position_reg <= mask_position_next;
            halted_reg        <= halted_next;
        end
    end

    // checks
    `WSFU_ASSERT(a_halt_sticks, halted_reg |=> halted_reg, "halt cleared without reset")
    `WSFU_ASSERT_ALWAYS(a_halt_silent, halted_reg |-> !res_valid, "result produced while halted")
    `WSFU_ASSERT(a_payload_len, (phase_reg == wsfu_pkg::PH_PAYLOAD) |-> (frame_length_reg != 64'd0), "payload phase with zero length")
    `WSFU_ASSERT_ALWAYS(a_ctrl_result, (res_valid && res.result_kind != wsfu_pkg::KIND_PAYLOAD) |-> (res.frame_last && res.out_byte == 8'd0), "malformed control result")

endmodule

FILE: sv/wsfu_out_reg.sv
// result register of the websocket frame unmasker
// uses wsfu_pkg for the result beat type
`timescale 1ns / 1ps

module wsfu_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  wsfu_pkg::result_t res,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic [1:0]        m_result_kind,
    output logic              m_frame_last
);

    logic              valid_reg;
    logic              valid_next;
    wsfu_pkg::result_t data_reg;

    // slot can take a new beat when empty or draining now
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = data_reg.out_byte;
    assign m_result_kind = data_reg.result_kind;
    assign m_frame_last  = data_reg.frame_last;

endmodule

FILE: sv/websocket_frame_unmasker_unit.sv
// top level of the websocket frame unmasker
// instantiates wsfu_in_reg, wsfu_deframer and wsfu_out_reg; uses wsfu_pkg
`timescale 1ns / 1ps

// Client-to-server WebSocket deframer: takes one stream byte per beat and
// accepts a byte every cycle while the result side keeps up. A byte passes
// through an input register, is decoded against the parser state and, if it
// yields a result, is loaded into the result register as it moves on.
// Header, extended-length and mask bytes give no payload result; each
// payload byte gives one unmasked byte with frame_last on the final one. A
// zero-length frame gives one empty-frame result; a frame without the mask
// bit gives one error result and the block then drops all input until
// reset. The 64-bit length decrement and zero compare set the cycle time.
module websocket_frame_unmasker_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_stream_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_result_kind,
    output logic       m_frame_last
);

    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              advance;
    logic              out_free;
    logic              res_valid;
    wsfu_pkg::result_t res;

    // a held byte moves on when the result slot can take its outcome
    assign advance = byte_valid && out_free;

    wsfu_in_reg u_in_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .advance       (advance),
        .byte_valid    (byte_valid),
        .byte_data     (byte_data)
    );

    wsfu_deframer u_deframer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfu_out_reg u_out_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance && res_valid),
        .res           (res),
        .free          (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_result_kind (m_result_kind),
        .m_frame_last  (m_frame_last)
    );

endmodule

FILE: dv/wsfu_checker.sv
// scoreboard for the websocket frame unmasker: watches both channels, predicts, compares
// depends on wsfu_pkg for result kinds, parser phases and header decode constants
`timescale 1ns / 1ps

module wsfu_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_stream_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic [1:0] m_result_kind,
    input  logic       m_frame_last,
    output int         fail_count,
    output int         pending,
    output int         beats_out
);

    // predicted result beats, oldest first
    wsfu_pkg::result_t unmasked_q[$];

    // shadow copy of the deframer state
    logic [2:0]  prs_phase;
    logic [3:0]  bytes_due;
    logic [63:0] len_left;
    logic [31:0] mask_key;
    logic        mask_on;
    logic [1:0]  key_idx;
    logic        locked;

    int fails = 0;
    int seen  = 0;

    assign fail_count = fails;
    assign pending    = unmasked_q.size();
    assign beats_out  = seen;

    // length fully known: error out on an unmasked frame, else collect the mask
    task automatic length_complete();
        if (!mask_on) begin
            locked    = 1'b1;
            prs_phase = wsfu_pkg::PH_HDR0;
            unmasked_q.push_back({8'h00, wsfu_pkg::KIND_UNMASKED, 1'b1});
        end else begin
            prs_phase = wsfu_pkg::PH_MASK;
            bytes_due = wsfu_pkg::MASK_BYTES;
        end
    endtask

    // advance the shadow parser by one stream byte
    task automatic deframe_byte(input logic [7:0] b);
        logic [6:0] code;
        logic [7:0] key;
        if (locked)
            return;
        case (prs_phase)
            wsfu_pkg::PH_HDR0: begin
                prs_phase = wsfu_pkg::PH_HDR1;
            end
            wsfu_pkg::PH_HDR1: begin
                code     = b[6:0];
                mask_on  = b[7];
                len_left = '0;
                if (code == wsfu_pkg::LEN_CODE_16) begin
                    bytes_due = wsfu_pkg::EXT_BYTES_16;
                    prs_phase = wsfu_pkg::PH_EXTLEN;
                end else if (code == wsfu_pkg::LEN_CODE_64) begin
                    bytes_due = wsfu_pkg::EXT_BYTES_64;
                    prs_phase = wsfu_pkg::PH_EXTLEN;
                end else begin
                    len_left = {57'd0, code};
                    length_complete();
                end
            end
            wsfu_pkg::PH_EXTLEN: begin
                len_left  = {len_left[55:0], b};
                bytes_due = bytes_due - 4'd1;
                if (bytes_due == 4'd0)
                    length_complete();
            end
            wsfu_pkg::PH_MASK: begin
                mask_key  = {mask_key[23:0], b};
                bytes_due = bytes_due - 4'd1;
                if (bytes_due == 4'd0) begin
                    key_idx = 2'd0;
                    if (len_left == 64'd0) begin
                        prs_phase = wsfu_pkg::PH_HDR0;
                        unmasked_q.push_back({8'h00, wsfu_pkg::KIND_EMPTY, 1'b1});
                    end else begin
                        prs_phase = wsfu_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsfu_pkg::PH_PAYLOAD: begin
                key      = mask_key[8 * (3 - key_idx) +: 8];
                key_idx  = key_idx + 2'd1;
                len_left = len_left - 64'd1;
                unmasked_q.push_back({b ^ key, wsfu_pkg::KIND_PAYLOAD, len_left == 64'd0});
                if (len_left == 64'd0)
                    prs_phase = wsfu_pkg::PH_HDR0;
            end
            default: begin
                prs_phase = wsfu_pkg::PH_HDR0;
            end
        endcase
    endtask

    // first ten failures get a line each, the rest are only counted
    task automatic note_failure(input string msg);
        fails++;
        if (fails <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // result beats are checked before the input beat of the same edge is predicted
    always @(posedge aclk) begin
        wsfu_pkg::result_t got;
        wsfu_pkg::result_t want;
        if (!aresetn) begin
            prs_phase = wsfu_pkg::PH_HDR0;
            bytes_due = '0;
            len_left  = '0;
            mask_key  = '0;
            mask_on   = 1'b0;
            key_idx   = '0;
            locked    = 1'b0;
            unmasked_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen++;
                got = {m_out_byte, m_result_kind, m_frame_last};
                if (unmasked_q.size() == 0) begin
                    note_failure($sformatf("unexpected beat byte %02h kind %0d last %0d",
                                           got.out_byte, got.result_kind, got.frame_last));
                end else begin
                    want = unmasked_q.pop_front();
                    if (got.out_byte !== want.out_byte ||
                        got.result_kind !== want.result_kind ||
                        got.frame_last !== want.frame_last)
                        note_failure($sformatf(
                            {"beat %0d exp byte %02h kind %0d last %0d, ",
                             "got byte %02h kind %0d last %0d"},
                            seen, want.out_byte, want.result_kind, want.frame_last,
                            got.out_byte, got.result_kind, got.frame_last));
                end
            end
            if (s_valid && s_ready)
                deframe_byte(s_stream_byte);
        end
    end

endmodule

FILE: dv/testbench.sv
// top of the websocket frame unmasker bench: clock, reset, frame stimulus and verdict
// instantiates websocket_frame_unmasker_unit and wsfu_checker; uses wsfu_pkg
`timescale 1ns / 1ps

module testbench;

    typedef enum logic [1:0] {
        ENC_DIRECT,
        ENC_EXT16,
        ENC_EXT64
    } len_enc_t;

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_stream_byte = 8'h00;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_out_byte;
    logic [1:0] m_result_kind;
    logic       m_frame_last;

    int fail_count;
    int pending;
    int beats_out;

    // no random idling on either side while set
    bit    calm        = 1'b0;
    int    bytes_sent  = 0;
    int    frames_sent = 0;
    string tail_case;

    websocket_frame_unmasker_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_result_kind (m_result_kind),
        .m_frame_last  (m_frame_last)
    );

    wsfu_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_result_kind (m_result_kind),
        .m_frame_last  (m_frame_last),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_out     (beats_out)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // result side stalls about 16 percent of the time, unless calm
    always @(posedge aclk) begin
        if (calm)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(0, 99) >= 16);
    end

    // hard stop
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // one input beat, with an optional gap in front; s_ready is sampled mid-cycle
    task automatic send_byte(input logic [7:0] b);
        bit taken;
        if (!calm && $urandom_range(0, 99) < 16) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        bytes_sent++;
    endtask

    // header, extended length and mask of one frame
    task automatic send_header(input logic [7:0] hdr0, input logic masked,
                               input len_enc_t enc, input logic [63:0] len,
                               input logic [31:0] key);
        logic [6:0] code;
        case (enc)
            ENC_DIRECT: code = len[6:0];
            ENC_EXT16:  code = wsfu_pkg::LEN_CODE_16;
            default:    code = wsfu_pkg::LEN_CODE_64;
        endcase
        send_byte(hdr0);
        send_byte({masked, code});
        if (enc == ENC_EXT16) begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end else if (enc == ENC_EXT64) begin
            for (int i = 7; i >= 0; i--)
                send_byte(len[8 * i +: 8]);
        end
        if (masked) begin
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
        end
        frames_sent++;
    endtask

    task automatic send_payload(input int count);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // well-formed masked frame with a random length and encoding, mostly short
    task automatic send_random_frame();
        int          pick;
        len_enc_t    enc;
        logic [63:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            enc = ENC_DIRECT;
            len = 64'd0;
        end else if (pick < 60) begin
            enc = ENC_DIRECT;
            len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(1, 125))
                                               : 64'($urandom_range(1, 12));
        end else if (pick < 80) begin
            // non-minimal 16-bit lengths mostly, now and then a real one
            enc = ENC_EXT16;
            len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(126, 300))
                                               : 64'($urandom_range(0, 20));
        end else begin
            enc = ENC_EXT64;
            len = 64'($urandom_range(0, 16));
        end
        send_header(8'($urandom_range(0, 255)), 1'b1, enc, len, $urandom);
        send_payload(int'(len));
    endtask

    initial begin
        int          rand_start;
        int          tail_pick;
        len_enc_t    enc;
        logic [63:0] len;

        // reset
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty frame with a direct length
        send_header(8'h81, 1'b1, ENC_DIRECT, 64'd0, 32'h1234_5678);
        // five bytes so the mask index wraps, extreme header and payload values
        send_header(8'hFF, 1'b1, ENC_DIRECT, 64'd5, 32'hFF00_AA55);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_byte(8'hC3);
        // single byte carried by the 64-bit length form
        send_header(8'h00, 1'b1, ENC_EXT64, 64'd1, 32'h0000_0000);
        send_byte(8'hFF);

        // random frames, with a stretch of no idling in the middle
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < 600) begin
            calm = (bytes_sent - rand_start >= 250) && (bytes_sent - rand_start < 400);
            send_random_frame();
        end
        calm = 1'b0;

        // the run ends in one of these, since each leaves the parser stuck
        tail_pick = $urandom_range(0, 2);
        if (tail_pick == 0) begin
            tail_case = "unmasked frame then ignored bytes";
            enc = len_enc_t'($urandom_range(0, 2));
            case (enc)
                ENC_DIRECT: len = 64'($urandom_range(0, 125));
                ENC_EXT16:  len = 64'($urandom_range(0, 65535));
                default:    len = {$urandom, $urandom};
            endcase
            send_header(8'($urandom_range(0, 255)), 1'b0, enc, len, 32'h0);
            send_payload(10);
        end else if (tail_pick == 1) begin
            // 16-bit length with its top bit set, payload cut short
            tail_case = "16-bit length with the top bit set, partial payload";
            len = 64'($urandom_range(32768, 65535));
            send_header(8'($urandom_range(0, 255)), 1'b1, ENC_EXT16, len, $urandom);
            send_payload(24);
        end else begin
            // length beyond 32 bits must not be cut down
            tail_case = "64-bit length above 32 bits, partial payload";
            len = {$urandom, $urandom};
            len[32 + $urandom_range(0, 31)] = 1'b1;
            send_header(8'($urandom_range(0, 255)), 1'b1, ENC_EXT64, len, $urandom);
            send_payload(24);
        end
        s_valid <= 1'b0;

        // drain, then leave room for stray beats
        while (pending != 0)
            @(negedge aclk);
        repeat (16) @(negedge aclk);

        $display("covered %0d stream bytes in %0d frames, %0d result beats checked",
                 bytes_sent, frames_sent, beats_out);
        $display("closing case: %s", tail_case);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
